FILE: hw/rtl/amc_pkg.sv
// Shared types, constants and the control program of the assignment matching counter.
// No dependencies; the top level imports it.
package amc_pkg;

   localparam int JOBS_DEFAULT = 6;
   localparam int MASK_W       = 6;
   localparam int COUNT_W      = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

   // Program steps
   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
   localparam logic [STEP_W-1:0] STEP_SWEEP  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_DRAIN  = 2'd2;
   localparam logic [STEP_W-1:0] STEP_FINISH = 2'd3;

   // Jump conditions: take the target when the condition holds, else hold the step
   localparam logic [1:0] JMP_ALWAYS   = 2'd0;
   localparam logic [1:0] JMP_ITEM     = 2'd1;
   localparam logic [1:0] JMP_LAST_ROW = 2'd2;
   localparam logic [1:0] JMP_OUT_FREE = 2'd3;

   typedef struct packed {
      logic              take_item;
      logic              sweep;
      logic              finish;
      logic [1:0]        jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '0;
      case (step)
         STEP_WAIT: begin
            uc.take_item = 1'b1;
            uc.jump      = JMP_ITEM;
            uc.target    = STEP_SWEEP;
         end
         STEP_SWEEP: begin
            uc.sweep  = 1'b1;
            uc.jump   = JMP_LAST_ROW;
            uc.target = STEP_DRAIN;
         end
         STEP_DRAIN: begin
            uc.jump   = JMP_ALWAYS;
            uc.target = STEP_FINISH;
         end
         STEP_FINISH: begin
            uc.finish = 1'b1;
            uc.jump   = JMP_OUT_FREE;
            uc.target = STEP_WAIT;
         end
         default: begin
            uc.jump   = JMP_ALWAYS;
            uc.target = STEP_WAIT;
         end
      endcase
      return uc;
   endfunction

endpackage

FILE: hw/rtl/amc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module amc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/assignment_matching_counter_top.sv
// Top level of the assignment matching counter: sequencer, lane RAMs and adder tree.
// Depends on amc_pkg and amc_ram.
//
// Counts the ways to give each worker a distinct job from the worker's job set.
// Input beats (req_*): one worker per beat, job set in req_tdata, req_tlast set on
// the final worker. Result beats (rsp_*): one beat after each final worker, holding
// the number of complete assignments (saturating at 1023).
// Each worker passes through an accept step, one sweep step per entry of the
// used-job-set table (64 at JOBS = 6), a drain step and a finish step.
// The sweep is set by the table RAM: one entry is rewritten per cycle, its inputs
// read from JOBS RAM copies in parallel. A result appears on rsp_tvalid the cycle
// after the finish step of the final worker.
// The table lives in two banks; each worker reads one bank and writes the other.
// After reset or a result, the read bank is taken as the start table (entry zero
// holds one) without touching the RAM, so no clearing pass is needed.
// The result sits in an output register; the next worker is accepted while it waits.
// Only the finish step of a later final worker holds until rsp_tready frees it.
// Reset is synchronous and returns the block to an empty tally.
module assignment_matching_counter_top
   import amc_pkg::*;
#(
   parameter int JOBS = JOBS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] job_mask, [7:6] zero
   input  logic        req_tlast,   // last_worker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [9:0] arrangement_count, [15:10] zero
);

   localparam int ROWS   = 1 << JOBS;
   localparam int ADDR_W = JOBS + 1;
   localparam int SUM_W  = COUNT_W + 4;

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [JOBS-1:0]    cnt_ff, cnt_in;
   logic [JOBS-1:0]    mask_ff, mask_in;
   logic               last_ff, last_in;
   logic               bank_ff, bank_in;
   logic               fresh_ff, fresh_in;
   logic               wr_en_ff, wr_en_in;
   logic [JOBS-1:0]    row_ff, row_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   ucode_type          uc;
   logic               accept;
   logic               out_free;
   logic               finish_go;
   logic [JOBS+MASK_W-1:0] mask_wide;
   logic [COUNT_W-1:0] rd_data [JOBS];
   logic [COUNT_W-1:0] row_sum;
   logic [SUM_W-1:0]   acc;
   logic [COUNT_W:0]   total_sum;

   assign uc         = ucode_rom(step_ff);
   assign req_tready = uc.take_item;
   assign accept     = req_tvalid && uc.take_item;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish_go  = uc.finish && (out_free || !last_ff);
   assign mask_wide  = {{JOBS{1'b0}}, req_tdata[MASK_W-1:0]};

   // One RAM copy per job lane, all written alike, each read at the row minus its job
   for (genvar j = 0; j < JOBS; j++) begin : g_lane
      logic [JOBS-1:0] src_row;
      assign src_row = cnt_ff ^ (JOBS'(1) << j);
      amc_ram #(
         .WIDTH (COUNT_W),
         .DEPTH (2 * ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en_ff),
         .wr_addr ({!bank_ff, row_ff}),
         .wr_data (row_sum),
         .rd_addr (ADDR_W'({bank_ff, src_row})),
         .rd_data (rd_data[j])
      );
   end

   // Sum the ways of every set that this row extends by one job of the worker
   always_comb begin
      logic [COUNT_W-1:0] term;
      acc = '0;
      for (int j = 0; j < JOBS; j++) begin
         if (fresh_ff) begin
            term = (row_ff == (JOBS'(1) << j)) ? COUNT_W'(1) : '0;
         end else begin
            term = rd_data[j];
         end
         if (mask_ff[j] && row_ff[j]) begin
            acc = acc + SUM_W'(term);
         end
      end
      row_sum = (acc > SUM_W'(COUNT_MAX)) ? COUNT_MAX : acc[COUNT_W-1:0];
   end

   assign total_sum = {1'b0, total_ff} + {1'b0, row_sum};

   always_comb begin
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      bank_in      = bank_ff;
      fresh_in     = fresh_ff;
      wr_en_in     = uc.sweep;
      row_in       = cnt_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         mask_in  = mask_wide[JOBS-1:0];
         last_in  = req_tlast;
         cnt_in   = '0;
         total_in = '0;
      end

      if (uc.sweep) begin
         cnt_in = cnt_ff + JOBS'(1);
      end

      if (wr_en_ff) begin
         total_in = (total_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : total_sum[COUNT_W-1:0];
      end

      if (finish_go) begin
         bank_in  = !bank_ff;
         fresh_in = last_ff;
         if (last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = total_ff;
         end
      end

      case (uc.jump)
         JMP_ALWAYS:   step_in = uc.target;
         JMP_ITEM:     if (accept) step_in = uc.target;
         JMP_LAST_ROW: if (cnt_ff == {JOBS{1'b1}}) step_in = uc.target;
         JMP_OUT_FREE: if (finish_go) step_in = uc.target;
         default:      step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         bank_ff      <= 1'b0;
         fresh_ff     <= 1'b1;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         bank_ff      <= bank_in;
         fresh_ff     <= fresh_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      mask_ff      <= mask_in;
      last_ff      <= last_in;
      row_ff       <= row_in;
      total_ff     <= total_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - COUNT_W){1'b0}}, rsp_count_ff};

   // A result only follows the finish step of a final worker
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == STEP_FINISH && last_ff))
      else $error("result without a finished final worker");

   // A final worker's finish holds while the previous result is stalled
   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_FINISH && last_ff && rsp_valid_ff && !rsp_tready)
      |=> (step_ff == STEP_FINISH && rsp_valid_ff))
      else $error("finish overran a stalled result");

   // Table writes stay within the sweep and the drain step after it
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> (step_ff == STEP_SWEEP || step_ff == STEP_DRAIN))
      else $error("table write outside the sweep");

   // The bank only flips once the last row is written
   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> $past(step_ff == STEP_FINISH && !wr_en_ff))
      else $error("bank flipped mid-sweep");

endmodule
